/* rtl/gqs_pkg.sv */
// gqs_pkg: shared types and constants for the glyph quad setup unit.
// No dependencies.
package gqs_pkg;

   localparam logic [2:0] ST_QUAD     = 3'd0;
   localparam logic [2:0] ST_EMPTY    = 3'd1;
   localparam logic [2:0] ST_BAD_SLOT = 3'd2;
   localparam logic [2:0] ST_BAD_REG  = 3'd3;
   localparam logic [2:0] ST_ORDER    = 3'd4;
   localparam logic [2:0] ST_GEOM     = 3'd5;

   localparam logic [2:0] CSR_ORIGIN_X = 3'd0;
   localparam logic [2:0] CSR_ORIGIN_Y = 3'd1;
   localparam logic [2:0] CSR_UPP      = 3'd2;
   localparam logic [2:0] CSR_BASE     = 3'd3;
   localparam logic [2:0] CSR_SLOTS    = 3'd4;
   localparam logic [2:0] CSR_BIND0    = 3'd5;
   localparam logic [2:0] CSR_BIND1    = 3'd6;
   localparam logic [2:0] CSR_BIND2    = 3'd7;

   localparam logic OP_START = 1'b0;
   localparam logic OP_GLYPH = 1'b1;

   // sequencer states, one-hot
   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_CHECK = 6'b000010,
      S_MUL   = 6'b000100,
      S_DIV   = 6'b001000,
      S_FIN   = 6'b010000,
      S_OUT   = 6'b100000
   } state_type;

endpackage

/* rtl/gqs_divider.sv */
// gqs_divider: restoring divider, one quotient bit per cycle.
// Depends on nothing; used by glyph_quad_setup_unit.
module gqs_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [32:0] dividend,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [32:0] quotient
);
   logic [32:0] quo_ff, quo_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] dsr_ff;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [17:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff, quo_ff[32]} - {2'b00, dsr_ff};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = 6'd33;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[17]) begin
            rem_in = trial[16:0];
            quo_in = {quo_ff[31:0], 1'b1};
         end else begin
            rem_in = {rem_ff[15:0], quo_ff[32]};
            quo_in = {quo_ff[31:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         dsr_ff <= divisor;
      end
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   assign done     = busy_ff && (cnt_ff == 6'd1);
   assign quotient = quo_in;
endmodule

/* rtl/glyph_quad_setup_unit.sv */
// glyph_quad_setup_unit: top level, glyph to screen quad setup.
// Depends on gqs_pkg and gqs_divider.
//
// Usage:
//  req_ channel carries one glyph or a start-of-run opcode per transfer.
//  A start opcode clears the glyph index and texture run tracking and
//  produces no result. A glyph produces exactly one rsp_ transfer.
//  csr_ channel writes one register (index 0..7) per transfer; write only
//  while the unit is idle. Indices beyond the list are ignored.
//  Steps: a quad passes a check state, then its edges on one 45x16
//  multiplier pair (one edge per cycle), an overflow judgement, four
//  texture coordinates on one bit-serial divider and an output state.
//  Slot, region, empty and order errors go from the check state straight
//  to the output state, geometry overflow from the overflow judgement.
//  One item is in flight at a time; req_ready returns the cycle after
//  the rsp_ transfer.
//  Reset (synchronous, active high) restores register defaults and clears
//  the index and run state. If rsp_ready is low the result stays held in
//  the output register and no further request is taken until it leaves.
module glyph_quad_setup_unit #(
   parameter int unsigned FONT_SLOTS = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [7:0]  req_font_slot,
   input  logic signed [31:0] req_pen_x,
   input  logic signed [31:0] req_baseline_y,
   input  logic signed [15:0] req_bearing_x,
   input  logic signed [15:0] req_bearing_y,
   input  logic [15:0] req_atlas_x,
   input  logic [15:0] req_atlas_y,
   input  logic [15:0] req_glyph_width,
   input  logic [15:0] req_glyph_height,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic signed [31:0] rsp_left_edge,
   output logic signed [31:0] rsp_top_edge,
   output logic signed [31:0] rsp_right_edge,
   output logic signed [31:0] rsp_bottom_edge,
   output logic [16:0] rsp_tex_u0,
   output logic [16:0] rsp_tex_v0,
   output logic [16:0] rsp_tex_u1,
   output logic [16:0] rsp_tex_v1,
   output logic [31:0] rsp_draw_order,
   output logic [31:0] rsp_texture_id,
   output logic        rsp_new_run,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);
   import gqs_pkg::*;

   localparam logic [31:0] ORDER_LIMIT = 32'hFFFF_FFFF;

   // configuration
   logic signed [31:0] org_x_ff, org_y_ff;
   logic [31:0] upp_ff, base_ff;
   logic [1:0]  slots_ff;
   logic [63:0] bind_ff [3];

   // run state
   logic [31:0] gcnt_ff;
   logic [31:0] last_tex_ff;
   logic        have_last_ff;

   state_type state_ff, state_in;

   // captured item
   logic [7:0]  slot_ff;
   logic signed [31:0] pen_ff, base_y_ff;
   logic signed [15:0] bx_ff, by_ff;
   logic [15:0] ax_ff, ay_ff, gw_ff, gh_ff;
   logic [31:0] idx_ff;

   // per-glyph work
   logic [1:0]  step_ff;          // edge / coord number
   logic [31:0] edge_ff [4];
   logic        bad_ff;
   logic [16:0] tc_ff [4];
   logic        div_go_ff;

   // selected binding
   logic [63:0] bind_sel;
   logic [15:0] aw, ah;
   logic [31:0] tex;
   logic [1:0]  slot_lim;

   assign bind_sel = bind_ff[slot_ff[1:0]];
   assign aw  = bind_sel[15:0];
   assign ah  = bind_sel[31:16];
   assign tex = bind_sel[63:32];
   assign slot_lim = (slots_ff < 2'(FONT_SLOTS)) ? slots_ff : 2'(FONT_SLOTS);

   // status decision, in check order
   logic [2:0] chk_status;
   logic [16:0] ax_end, ay_end;
   always_comb begin
      ax_end = {1'b0, ax_ff} + {1'b0, gw_ff};
      ay_end = {1'b0, ay_ff} + {1'b0, gh_ff};
      chk_status = ST_QUAD;
      if ({6'd0, slot_lim} <= slot_ff) begin
         chk_status = ST_BAD_SLOT;
      end else if ((gw_ff == 16'd0) != (gh_ff == 16'd0)) begin
         chk_status = ST_BAD_REG;
      end else if (gw_ff == 16'd0) begin
         chk_status = ST_EMPTY;
      end else if (ax_end > {1'b0, aw} || ay_end > {1'b0, ah}) begin
         chk_status = ST_BAD_REG;
      end else if (idx_ff >= ORDER_LIMIT || base_ff > ORDER_LIMIT - 32'd1 - idx_ff) begin
         chk_status = ST_ORDER;
      end
   end

   // edge placement: one edge per cycle
   // pos is Q.16, |pos| < 2^44
   logic signed [45:0] pos;
   logic [44:0] mag_pos;
   logic [60:0] p_hi;
   logic [60:0] p_lo;
   logic [60:0] mag;
   logic signed [62:0] edge_full;
   logic signed [31:0] org_sel;
   always_comb begin
      case (step_ff)
         2'd0: pos = 46'(pen_ff) * 46'sd1024 + 46'(bx_ff) * 46'sd65536;
         2'd1: pos = 46'(base_y_ff) * 46'sd1024 - 46'(by_ff) * 46'sd65536;
         2'd2: pos = 46'(pen_ff) * 46'sd1024 + 46'(bx_ff) * 46'sd65536
                   + $signed({14'd0, gw_ff, 16'd0});
         default: pos = 46'(base_y_ff) * 46'sd1024 - 46'(by_ff) * 46'sd65536
                   + $signed({14'd0, gh_ff, 16'd0});
      endcase
      org_sel = step_ff[0] ? org_y_ff : org_x_ff;
      mag_pos = pos[45] ? 45'(-pos) : pos[44:0];
      p_hi = 61'(mag_pos) * 61'(upp_ff[31:16]);
      p_lo = 61'(mag_pos) * 61'(upp_ff[15:0]);
      mag  = p_hi + ((p_lo + 61'h8000) >> 16);
      edge_full = pos[45] ? 63'(org_sel) - $signed({2'b00, mag})
                          : 63'(org_sel) + $signed({2'b00, mag});
   end
   logic edge_bad;
   assign edge_bad = (edge_full < -63'sd2147483648) || (edge_full > 63'sd2147483647);

   // texture coordinate divider
   logic [32:0] dvd;
   logic [15:0] dvs;
   logic        div_done;
   logic [32:0] div_q;
   always_comb begin
      case (step_ff)
         2'd0: begin dvd = {1'b0, ax_ff, 16'd0} + 33'(aw[15:1]); dvs = aw; end
         2'd1: begin dvd = {1'b0, ay_ff, 16'd0} + 33'(ah[15:1]); dvs = ah; end
         2'd2: begin dvd = {ax_end, 16'd0} + 33'(aw[15:1]); dvs = aw; end
         default: begin dvd = {ay_end, 16'd0} + 33'(ah[15:1]); dvs = ah; end
      endcase
   end

   gqs_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go_ff),
      .dividend (dvd),
      .divisor  (dvs),
      .done     (div_done),
      .quotient (div_q)
   );

   // output register
   logic        out_v_ff;
   logic [2:0]  o_st_ff;
   logic        o_nr_ff;
   logic [31:0] o_do_ff, o_tex_ff;

   logic req_fire, rsp_fire;
   assign req_ready = (state_ff == S_IDLE) && !out_v_ff;
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = out_v_ff && rsp_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_fire && req_opcode == OP_GLYPH) state_in = S_CHECK;
         S_CHECK: state_in = (chk_status == ST_QUAD) ? S_MUL : S_OUT;
         S_MUL:   if (step_ff == 2'd3) state_in = S_FIN;
         S_FIN:   state_in = bad_ff ? S_OUT : S_DIV;
         S_DIV:   if (div_done && step_ff == 2'd3) state_in = S_OUT;
         S_OUT:   state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         slot_ff   <= req_font_slot;
         pen_ff    <= req_pen_x;
         base_y_ff <= req_baseline_y;
         bx_ff     <= req_bearing_x;
         by_ff     <= req_bearing_y;
         ax_ff     <= req_atlas_x;
         ay_ff     <= req_atlas_y;
         gw_ff     <= req_glyph_width;
         gh_ff     <= req_glyph_height;
         idx_ff    <= gcnt_ff;
      end
      case (state_ff)
         S_CHECK: begin
            step_ff   <= 2'd0;
            bad_ff    <= 1'b0;
            o_st_ff   <= chk_status;
            div_go_ff <= 1'b0;
         end
         S_MUL: begin
            edge_ff[step_ff] <= 32'(edge_full);
            bad_ff    <= bad_ff | edge_bad;
            step_ff   <= step_ff + 2'd1;
            div_go_ff <= 1'b0;
         end
         S_FIN: begin
            step_ff   <= 2'd0;
            div_go_ff <= !bad_ff;
            if (bad_ff) o_st_ff <= ST_GEOM;
         end
         S_DIV: begin
            if (div_done) begin
               tc_ff[step_ff] <= div_q[16:0];
               step_ff <= step_ff + 2'd1;
               div_go_ff <= (step_ff != 2'd3);
            end else begin
               div_go_ff <= 1'b0;
            end
         end
         S_OUT: begin
            o_do_ff   <= base_ff + idx_ff;
            o_tex_ff  <= tex;
            o_nr_ff   <= !have_last_ff || (last_tex_ff != tex);
            div_go_ff <= 1'b0;
         end
         default: div_go_ff <= 1'b0;
      endcase

      if (reset) begin
         state_ff     <= S_IDLE;
         out_v_ff     <= 1'b0;
         gcnt_ff      <= '0;
         last_tex_ff  <= '0;
         have_last_ff <= 1'b0;
         org_x_ff     <= '0;
         org_y_ff     <= '0;
         upp_ff       <= 32'd65536;
         base_ff      <= '0;
         slots_ff     <= 2'd1;
         bind_ff[0]   <= '0;
         bind_ff[1]   <= '0;
         bind_ff[2]   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_OUT) begin
            out_v_ff <= 1'b1;
            if (o_st_ff == ST_QUAD) begin
               last_tex_ff  <= tex;
               have_last_ff <= 1'b1;
            end
         end else if (rsp_fire) begin
            out_v_ff <= 1'b0;
         end
         if (req_fire) begin
            if (req_opcode == OP_START) begin
               gcnt_ff      <= '0;
               last_tex_ff  <= '0;
               have_last_ff <= 1'b0;
            end else if (gcnt_ff != 32'hFFFF_FFFF) begin
               gcnt_ff <= gcnt_ff + 32'd1;
            end
         end
         if (csr_valid) begin
            case (csr_index)
               CSR_ORIGIN_X: org_x_ff   <= csr_data[31:0];
               CSR_ORIGIN_Y: org_y_ff   <= csr_data[31:0];
               CSR_UPP:      upp_ff     <= csr_data[31:0];
               CSR_BASE:     base_ff    <= csr_data[31:0];
               CSR_SLOTS:    slots_ff   <= csr_data[1:0];
               CSR_BIND0:    bind_ff[0] <= csr_data;
               CSR_BIND1:    bind_ff[1] <= csr_data;
               CSR_BIND2:    bind_ff[2] <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // non-quad results carry zeros in every field but status
   logic q;
   assign q = (o_st_ff == ST_QUAD);
   assign rsp_valid       = out_v_ff;
   assign rsp_status      = o_st_ff;
   assign rsp_left_edge   = q ? edge_ff[0] : '0;
   assign rsp_top_edge    = q ? edge_ff[1] : '0;
   assign rsp_right_edge  = q ? edge_ff[2] : '0;
   assign rsp_bottom_edge = q ? edge_ff[3] : '0;
   assign rsp_tex_u0      = q ? tc_ff[0] : '0;
   assign rsp_tex_v0      = q ? tc_ff[1] : '0;
   assign rsp_tex_u1      = q ? tc_ff[2] : '0;
   assign rsp_tex_v1      = q ? tc_ff[3] : '0;
   assign rsp_draw_order  = q ? o_do_ff : '0;
   assign rsp_texture_id  = q ? o_tex_ff : '0;
   assign rsp_new_run     = q ? o_nr_ff : 1'b0;

`ifndef SYNTHESIS
   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_ready) else $error("req taken while busy");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !rsp_ready) |=> (out_v_ff && $stable(o_st_ff)))
      else $error("result dropped");
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      out_v_ff |-> (o_st_ff <= ST_GEOM)) else $error("bad status");
`endif
endmodule
